@@ design/prefix_id_table_defines.svh @@
// Assertion macros for the prefix id table checker.
`ifndef PREFIX_ID_TABLE_DEFINES_SVH
`define PREFIX_ID_TABLE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define PIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pit_pkg.sv @@
// Package for the prefix id table: widths, codes and the prefix mask helper.
package pit_pkg;

  localparam int PIT_CAPACITY         = 128;
  localparam int PIT_PREFIX_BYTES_MAX = 8;

  localparam int CMD_W  = 2;
  localparam int ADDR_W = 64;
  localparam int PB_W   = 4;
  localparam int IDX_W  = 7;
  localparam int ST_W   = 3;
  localparam int USED_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } pit_cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_HIT          = 3'd0,
    ST_INSERTED     = 3'd1,
    ST_MISS         = 3'd2,
    ST_FULL         = 3'd3,
    ST_READ_OK      = 3'd4,
    ST_OUT_OF_RANGE = 3'd5,
    ST_CLEARED      = 3'd6
  } pit_status_t;

  // One result beat.
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    pit_status_t       status;
    logic [ADDR_W-1:0] stored_prefix;
    logic [USED_W-1:0] entries_used;
  } pit_res_t;

  // Build a byte mask covering the leading nbytes bytes (byte 0 is the MSB).
  function automatic logic [ADDR_W-1:0] pit_mask(input logic [PB_W-1:0] nbytes);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int b = 0; b < ADDR_W / 8; b++) begin
      if (PB_W'(b) < nbytes) begin
        m[ADDR_W-1-8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

@@ design/pit_ifs.sv @@
// Valid/ready channel interfaces for the command and result beats.
interface pit_in_if;
  logic                      valid;
  logic                      ready;
  logic [pit_pkg::CMD_W-1:0]  command;
  logic [pit_pkg::ADDR_W-1:0] address;
  logic [pit_pkg::PB_W-1:0]   prefix_bytes;
  logic [pit_pkg::IDX_W-1:0]  entry_index;

  modport source (output valid, command, address, prefix_bytes, entry_index,
                  input ready);
  modport sink   (input valid, command, address, prefix_bytes, entry_index,
                  output ready);
endinterface

interface pit_out_if;
  logic                       valid;
  logic                       ready;
  logic [pit_pkg::IDX_W-1:0]  index;
  logic [pit_pkg::ST_W-1:0]   status;
  logic [pit_pkg::ADDR_W-1:0] stored_prefix;
  logic [pit_pkg::USED_W-1:0] entries_used;

  modport source (output valid, index, status, stored_prefix, entries_used,
                  input ready);
  modport sink   (input valid, index, status, stored_prefix, entries_used,
                  output ready);
endinterface

@@ design/pit_store.sv @@
// Prefix storage: single write port, one registered read port.
module pit_store #(
  parameter int DEPTH = pit_pkg::PIT_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [pit_pkg::ADDR_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [pit_pkg::ADDR_W-1:0] rd_data
);

  logic [pit_pkg::ADDR_W-1:0] mem [DEPTH];
  logic [pit_pkg::ADDR_W-1:0] rd_data_r;

  // Write the new entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/prefix_id_table.sv @@
// Prefix id table top level: command sequencer around the prefix store.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    command, address, prefix_bytes, entry_index
//   out_ch    out  valid/ready    index, status, stored_prefix, entries_used
//
// Insert and lookup scan the store one entry per cycle through its single read
// port; a hit ends the scan at the matching entry, a miss scans every entry.
// Read passes through S_READ to S_EMIT; clear and out-of-range go to S_EMIT.
// Reset clears the entry count and the output valid flag; the store holds no
// reset state. A stalled result beat holds in the output register while the
// next command is taken; that command finishes once the register frees.
module prefix_id_table #(
  parameter int CAPACITY         = pit_pkg::PIT_CAPACITY,
  parameter int PREFIX_BYTES_MAX = pit_pkg::PIT_PREFIX_BYTES_MAX
) (
  input  logic      clk,
  input  logic      rst_n,
  pit_in_if.sink    in_ch,
  pit_out_if.source out_ch
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > pit_pkg::IDX_W) ? CW : pit_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_READ,
    S_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  pit_pkg::pit_cmd_t          cmd_r, cmd_nxt;
  logic [pit_pkg::ADDR_W-1:0] key_r, key_nxt;
  logic [pit_pkg::ADDR_W-1:0] mask_r, mask_nxt;
  logic [AW-1:0]              scan_r, scan_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  pit_pkg::pit_res_t          res_r, res_nxt;
  pit_pkg::pit_res_t          out_res_r, out_res_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [pit_pkg::ADDR_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [pit_pkg::ADDR_W-1:0] rd_data;

  logic [pit_pkg::PB_W-1:0]   nbytes;
  logic                       hit;
  logic                       last_entry;
  logic                       read_in_range;
  pit_pkg::pit_cmd_t          in_cmd;

  pit_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_pit_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Clamp the prefix length and decode the incoming beat.
  assign nbytes = (in_ch.prefix_bytes > pit_pkg::PB_W'(PREFIX_BYTES_MAX)) ?
                  pit_pkg::PB_W'(PREFIX_BYTES_MAX) : in_ch.prefix_bytes;
  assign in_cmd = pit_pkg::pit_cmd_t'(in_ch.command);
  assign read_in_range = CMPW'(in_ch.entry_index) < CMPW'(count_r);

  // Compare the word read last cycle against the key.
  assign hit        = ((rd_data ^ key_r) & mask_r) == '0;
  assign last_entry = (CW'(scan_r) + 1'b1) == count_r;

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequence one command at a time.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    mask_nxt      = mask_r;
    scan_nxt      = scan_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = key_r & mask_r;
    rd_en         = 1'b0;
    rd_addr       = scan_r + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt  = in_cmd;
          key_nxt  = in_ch.address;
          mask_nxt = pit_pkg::pit_mask(nbytes);
          scan_nxt = '0;
          unique case (in_cmd)
            pit_pkg::CMD_INSERT, pit_pkg::CMD_LOOKUP: begin
              if (count_r == '0) begin
                state_nxt = S_MISS;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SCAN;
              end
            end
            pit_pkg::CMD_READ: begin
              if (read_in_range) begin
                rd_en         = 1'b1;
                rd_addr       = AW'(in_ch.entry_index);
                res_nxt.index = in_ch.entry_index;
                state_nxt     = S_READ;
              end else begin
                res_nxt.index         = '0;
                res_nxt.status        = pit_pkg::ST_OUT_OF_RANGE;
                res_nxt.stored_prefix = '0;
                res_nxt.entries_used  = pit_pkg::USED_W'(count_r);
                state_nxt             = S_EMIT;
              end
            end
            pit_pkg::CMD_CLEAR: begin
              count_nxt             = '0;
              res_nxt.index         = '0;
              res_nxt.status        = pit_pkg::ST_CLEARED;
              res_nxt.stored_prefix = '0;
              res_nxt.entries_used  = '0;
              state_nxt             = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_nxt.index         = pit_pkg::IDX_W'(scan_r);
          res_nxt.status        = pit_pkg::ST_HIT;
          res_nxt.stored_prefix = '0;
          res_nxt.entries_used  = pit_pkg::USED_W'(count_r);
          state_nxt             = S_EMIT;
        end else if (last_entry) begin
          state_nxt = S_MISS;
        end else begin
          rd_en    = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_MISS: begin
        res_nxt.stored_prefix = '0;
        if (cmd_r == pit_pkg::CMD_LOOKUP) begin
          res_nxt.index        = '0;
          res_nxt.status       = pit_pkg::ST_MISS;
          res_nxt.entries_used = pit_pkg::USED_W'(count_r);
        end else if (count_r == CW'(CAPACITY)) begin
          res_nxt.index        = '0;
          res_nxt.status       = pit_pkg::ST_FULL;
          res_nxt.entries_used = pit_pkg::USED_W'(count_r);
        end else begin
          // Append the masked prefix at the end of the table.
          wr_en                = 1'b1;
          count_nxt            = CW'(count_r + 1'b1);
          res_nxt.index        = pit_pkg::IDX_W'(count_r);
          res_nxt.status       = pit_pkg::ST_INSERTED;
          res_nxt.entries_used = pit_pkg::USED_W'(count_nxt);
        end
        state_nxt = S_EMIT;
      end

      S_READ: begin
        res_nxt.status        = pit_pkg::ST_READ_OK;
        res_nxt.stored_prefix = rd_data;
        res_nxt.entries_used  = pit_pkg::USED_W'(count_r);
        state_nxt             = S_EMIT;
      end

      S_EMIT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, count and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
      key_r       <= key_nxt;
      mask_r      <= mask_nxt;
      scan_r      <= scan_nxt;
      res_r       <= res_nxt;
      out_res_r   <= out_res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.index         = out_res_r.index;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.stored_prefix = out_res_r.stored_prefix;
  assign out_ch.entries_used  = out_res_r.entries_used;

endmodule

@@ design/pit_checker.sv @@
// Port-level checks on the prefix id table result channel, bound to the top.
`include "prefix_id_table_defines.svh"

module pit_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pit_pkg::IDX_W-1:0]  out_index,
  input logic [pit_pkg::ST_W-1:0]   out_status,
  input logic [pit_pkg::ADDR_W-1:0] out_stored_prefix,
  input logic [pit_pkg::USED_W-1:0] out_entries_used
);

  // Hold a stalled result beat.
  `PIT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  // A found, added or read index lies inside the table.
  `PIT_ASSERT_NOW(a_index_in_table, out_valid && (out_status == pit_pkg::ST_HIT || out_status == pit_pkg::ST_INSERTED || out_status == pit_pkg::ST_READ_OK), {1'b0, out_index} < out_entries_used, "index beyond entry count")

  // Only a good read carries a prefix.
  `PIT_ASSERT_NOW(a_prefix_only_on_read, out_valid && out_status != pit_pkg::ST_READ_OK, out_stored_prefix == '0, "prefix on non-read result")

  // A clear leaves an empty table.
  `PIT_ASSERT_NOW(a_clear_empties, out_valid && out_status == pit_pkg::ST_CLEARED, out_entries_used == '0 && out_index == '0, "clear left entries")

endmodule

bind prefix_id_table pit_checker u_pit_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_index         (out_ch.index),
  .out_status        (out_ch.status),
  .out_stored_prefix (out_ch.stored_prefix),
  .out_entries_used  (out_ch.entries_used)
);
